FILE: design/msr_pkg.sv
package msr_pkg;

    localparam int ELEM_W = 16;
    localparam int SUM_W  = 31;
    localparam int DIM_W  = 8;

    localparam logic [DIM_W-1:0] DIM_RESET = 8'd128;

    // most negative 31-bit value, -2^30
    localparam logic signed [SUM_W-1:0] MOST_NEG = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_LOAD,
        S_LWRITE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // one read of the column scan, travelling alongside the memory read
    typedef struct packed {
        logic valid;
        logic first;
        logic use_top;
    } t_scan_ctl;

endpackage

FILE: design/msr_ram.sv
module msr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16384
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/msr_scan.sv
module msr_scan (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  msr_pkg::t_scan_ctl                    i_ctl,
    input  logic signed [msr_pkg::SUM_W-1:0]      i_bot_sum,
    input  logic signed [msr_pkg::SUM_W-1:0]      i_top_sum,
    input  logic                                  i_clear,
    output logic                                  o_busy,
    output logic signed [msr_pkg::SUM_W-1:0]      o_best
);

    logic                               r_col_vld;
    logic                               r_col_first;
    logic signed [msr_pkg::SUM_W-1:0]   r_col;
    logic                               r_run_vld;
    logic signed [msr_pkg::SUM_W-1:0]   r_run;
    logic signed [msr_pkg::SUM_W-1:0]   r_best;

    logic signed [msr_pkg::SUM_W-1:0]   n_col;
    logic signed [msr_pkg::SUM_W-1:0]   n_run;
    logic signed [msr_pkg::SUM_W-1:0]   n_best;

    // column sum between the top and bottom row
    always_comb begin
        if (i_ctl.use_top) begin
            n_col = i_bot_sum - i_top_sum;
        end else begin
            n_col = i_bot_sum;
        end
    end

    // restart the run when it went negative or a new row pair begins
    always_comb begin
        if (r_col_first || r_run < 0) begin
            n_run = r_col;
        end else begin
            n_run = r_run + r_col;
        end
    end

    always_comb begin
        n_best = r_best;
        if (i_clear) begin
            n_best = msr_pkg::MOST_NEG;
        end else if (r_run_vld && r_run > r_best) begin
            n_best = r_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_vld   <= 1'b0;
            r_col_first <= 1'b0;
            r_run_vld   <= 1'b0;
            r_best      <= msr_pkg::MOST_NEG;
        end else begin
            r_col_vld   <= i_ctl.valid;
            r_col_first <= i_ctl.first;
            r_run_vld   <= r_col_vld;
            r_best      <= n_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_col <= n_col;
        end
        if (r_col_vld) begin
            r_run <= n_run;
        end
    end

    assign o_busy = i_ctl.valid | r_col_vld | r_run_vld;
    assign o_best = r_best;

endmodule

FILE: design/max_sum_subrectangle.sv
// Maximum-sum sub-rectangle of a square matrix.
// The side length N comes from the configuration channel (i_cfg_valid,
// o_cfg_ready, i_cfg_data); 0 counts as 1 and values above MAX_DIM saturate.
// A write restarts the load, so the next element becomes element (0,0).
// o_cfg_ready is high only while the block waits for an element.
// Elements arrive in row-major order on i_in_valid / o_in_stall /
// i_element_value. For each element the block reads the column prefix
// of the row above from memory, then writes the new prefix.
// After element N*N-1 the block scans every top/bottom row pair with a
// running maximum over the columns, one memory read per cycle, and then
// drains the scan pipeline, while o_in_stall stays high. The single
// result then moves into the output register (o_out_valid / i_out_stall /
// o_max_sum) and loading of the next matrix starts at once, while the
// result waits for the receiver. If a second result is ready before the
// first is taken, the block holds it until the output register frees up.
// Reset clears the load position, the running maximum and the output valid,
// and sets N to 128. The prefix memory needs no clearing: only entries
// written during the current load are used.
module max_sum_subrectangle #(
    parameter int MAX_DIM = 128
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [msr_pkg::DIM_W-1:0]            i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [msr_pkg::ELEM_W-1:0]    i_element_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [msr_pkg::SUM_W-1:0]     o_max_sum
);

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int NW    = $clog2(MAX_DIM + 1);
    localparam int CW    = (NW > msr_pkg::DIM_W) ? NW : msr_pkg::DIM_W;
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int SW    = msr_pkg::SUM_W;
    localparam int EW    = msr_pkg::ELEM_W;

    msr_pkg::t_state r_state, n_state;

    logic [msr_pkg::DIM_W-1:0] r_dim;
    logic [IW-1:0]             r_row, n_row;
    logic [IW-1:0]             r_col, n_col;
    logic [IW-1:0]             r_top, n_top;
    logic [IW-1:0]             r_bot, n_bot;
    logic signed [EW-1:0]      r_elem;
    msr_pkg::t_scan_ctl        r_ctl, n_ctl;
    logic                      r_out_vld, n_out_vld;
    logic signed [SW-1:0]      r_out;

    logic [CW-1:0]        w_dim_ext;
    logic [NW-1:0]        w_side;
    logic [IW-1:0]        w_last;
    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_xfer;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic signed [SW-1:0] w_wdata;
    logic [AW-1:0]        w_raddr_a;
    logic [AW-1:0]        w_raddr_b;
    logic signed [SW-1:0] w_rdata_a;
    logic signed [SW-1:0] w_rdata_b;
    logic                 w_load_last;
    logic                 w_scan_last;
    logic                 w_scan_busy;
    logic signed [SW-1:0] w_best;

    // effective side length
    always_comb begin
        w_dim_ext = CW'(r_dim);
        if (r_dim == '0) begin
            w_side = NW'(1);
        end else if (w_dim_ext > CW'(MAX_DIM)) begin
            w_side = NW'(MAX_DIM);
        end else begin
            w_side = NW'(w_dim_ext);
        end
    end

    assign w_last      = IW'(w_side - NW'(1));
    assign o_cfg_ready = (r_state == msr_pkg::S_LOAD);
    assign o_in_stall  = (r_state != msr_pkg::S_LOAD);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_vld || !i_out_stall;
    assign w_load_last = (r_row == w_last) && (r_col == w_last);
    assign w_scan_last = (r_top == w_last) && (r_bot == w_last) && (r_col == w_last);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            msr_pkg::S_LOAD: begin
                if (w_in_acc) begin
                    n_state = msr_pkg::S_LWRITE;
                end
            end
            msr_pkg::S_LWRITE: begin
                if (w_load_last) begin
                    n_state = msr_pkg::S_SCAN;
                end else begin
                    n_state = msr_pkg::S_LOAD;
                end
            end
            msr_pkg::S_SCAN: begin
                if (w_scan_last) begin
                    n_state = msr_pkg::S_DRAIN;
                end
            end
            msr_pkg::S_DRAIN: begin
                if (!w_scan_busy) begin
                    n_state = msr_pkg::S_DONE;
                end
            end
            msr_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = msr_pkg::S_LOAD;
                end
            end
            default: n_state = msr_pkg::S_LOAD;
        endcase
    end

    // outputs, memory controls and counters
    always_comb begin
        n_row     = r_row;
        n_col     = r_col;
        n_top     = r_top;
        n_bot     = r_bot;
        n_ctl     = '0;
        w_we      = 1'b0;
        w_xfer    = 1'b0;
        w_waddr   = {r_row, r_col};
        w_raddr_a = {r_row - IW'(1), r_col};
        w_raddr_b = {r_top - IW'(1), r_col};
        if (r_row == '0) begin
            w_wdata = {{(SW-EW){r_elem[EW-1]}}, r_elem};
        end else begin
            w_wdata = {{(SW-EW){r_elem[EW-1]}}, r_elem} + w_rdata_a;
        end
        unique case (r_state)
            msr_pkg::S_LOAD: begin
            end
            msr_pkg::S_LWRITE: begin
                w_we = 1'b1;
                if (w_load_last) begin
                    n_row = '0;
                    n_col = '0;
                    n_top = '0;
                    n_bot = '0;
                end else if (r_col == w_last) begin
                    n_col = '0;
                    n_row = r_row + IW'(1);
                end else begin
                    n_col = r_col + IW'(1);
                end
            end
            msr_pkg::S_SCAN: begin
                w_raddr_a     = {r_bot, r_col};
                n_ctl.valid   = 1'b1;
                n_ctl.first   = (r_col == '0);
                n_ctl.use_top = (r_top != '0);
                if (r_col != w_last) begin
                    n_col = r_col + IW'(1);
                end else begin
                    n_col = '0;
                    if (r_bot != w_last) begin
                        n_bot = r_bot + IW'(1);
                    end else if (r_top != w_last) begin
                        n_top = r_top + IW'(1);
                        n_bot = r_top + IW'(1);
                    end else begin
                        n_top = '0;
                        n_bot = '0;
                    end
                end
            end
            msr_pkg::S_DRAIN: begin
            end
            msr_pkg::S_DONE: begin
                w_xfer = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_out_valid && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
        if (w_xfer) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= msr_pkg::S_LOAD;
            r_dim     <= msr_pkg::DIM_RESET;
            r_row     <= '0;
            r_col     <= '0;
            r_top     <= '0;
            r_bot     <= '0;
            r_ctl     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_col     <= n_col;
            r_top     <= n_top;
            r_bot     <= n_bot;
            r_ctl     <= n_ctl;
            r_out_vld <= n_out_vld;
            // an element taken at the same edge becomes element (0,0)
            if (i_cfg_valid && o_cfg_ready) begin
                r_dim   <= i_cfg_data;
                r_row   <= '0;
                r_col   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_elem <= i_element_value;
        end
        if (w_xfer) begin
            r_out <= w_best;
        end
    end

    // two copies of the column prefix sums, one read port each
    msr_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ram_bot (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rdata_a)
    );

    msr_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ram_top (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rdata_b)
    );

    msr_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (r_ctl),
        .i_bot_sum (w_rdata_a),
        .i_top_sum (w_rdata_b),
        .i_clear   (w_xfer),
        .o_busy    (w_scan_busy),
        .o_best    (w_best)
    );

    assign o_out_valid = r_out_vld;
    assign o_max_sum   = r_out;

`ifndef NO_ASSERTIONS
    a_xfer_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer |=> o_out_valid)
        else $error("result transfer did not raise output valid");

    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msr_pkg::S_DONE) |-> !w_scan_busy)
        else $error("result taken while scan pipeline busy");

    a_load_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msr_pkg::S_LOAD) |-> (r_row <= w_last && r_col <= w_last))
        else $error("load position outside the matrix");

    a_rows_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msr_pkg::S_SCAN) |-> (r_bot >= r_top && r_bot <= w_last))
        else $error("row pair out of order");
`endif

endmodule
